[hw/rtl/indexed_list_insert_remove_search_core_defines.svh]
// ----------------------------------------------------------------------------
// Indexed list core - assertion macros
// Shared assertion wrappers for the list core, clocked on clk with arst_n.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_SEARCH_CORE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_SEARCH_CORE_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define ILIST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every rising edge outside reset.
`define ILIST_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ilist_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed list package
// Types and constants shared by the list cells and the list core.
// ----------------------------------------------------------------------------
package ilist_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 64;
	localparam int POS_W        = 7;
	localparam int MODE_W       = 3;
	localparam int STATUS_W     = 2;
	localparam int IN_TDATA_W   = 80;
	localparam int OUT_TDATA_W  = 80;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_INSERT = 3'd1,
		MODE_REMOVE = 3'd2,
		MODE_READ   = 3'd3,
		MODE_FIND   = 3'd4,
		MODE_CLEAR  = 3'd5,
		MODE_SIZE   = 3'd6
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_COLLECT
	} state_t;

	// Command broadcast to every cell during the execute cycle
	typedef struct packed {
		logic up;    // open a slot at pos, later entries move up
		logic down;  // close the slot at pos, later entries move down
		logic find;  // compare against the search value
		logic read;  // present the entry at pos
	} cell_cmd_t;

endpackage

[hw/rtl/indexed_list_insert_remove_search_core.sv]
// ----------------------------------------------------------------------------
// Indexed list core
// Bounded ordered list of signed 64-bit values held in a row of shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Operations arrive on the s_ stream, one transfer per operation; each
//   operation yields exactly one result transfer on the m_ stream.
//   s_tdata holds mode, position and the value; m_tdata holds status,
//   read value, found position and the entry count after the operation.
//   Steps: accept, execute in the cell row (all cells shift or compare
//   in parallel), then collect the hit and read lines into the output
//   register. s_tready is low in execute and collect, so a new operation
//   is taken only once the previous one has been collected.
//   The output register decouples the sides: a new operation is taken
//   while the previous result still waits. If the receiver stalls, the
//   following result waits in the collect step and s_tready stays low.
//   Reset empties the list (count to zero) and drops any pending result;
//   cell contents are left as they are and only entries below the count
//   are ever read or searched.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_remove_search_core_defines.svh"

module indexed_list_insert_remove_search_core
	import ilist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [2:0] mode, [9:3] position, [73:10] item_value, [79:74] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] status, [65:2] read_value, [72:66] found_position, [79:73] entry_count
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0]   CAP_CW   = CW'(CAPACITY);
	localparam logic [CMPW-1:0] CAP_CMPW = CMPW'(CAPACITY);

	state_t state_q, state_d;

	logic [CW-1:0] count_q;

	// operation stage
	cell_cmd_t         cmd_s1;
	logic [CMPW-1:0]   pos_s1;
	logic [DATA_W-1:0] value_s1;
	status_t           status_s1;

	// output register
	logic                out_valid_q;
	status_t             status_q;
	logic [DATA_W-1:0]   read_q;
	logic [POS_W-1:0]    found_q;
	logic [POS_W-1:0]    count_out_q;

	// input unpacking
	logic [MODE_W-1:0] in_mode;
	logic [CMPW-1:0]   in_pos;
	logic [DATA_W-1:0] in_value;
	logic [CMPW-1:0]   count_ext;
	logic              accept;
	logic              load_out;

	cell_cmd_t         cmd_d;
	logic [CMPW-1:0]   pos_d;
	status_t           status_d;
	logic [CW-1:0]     count_d;

	assign in_mode   = s_tdata[2:0];
	assign in_pos    = CMPW'(s_tdata[9:3]);
	assign in_value  = s_tdata[73:10];
	assign count_ext = CMPW'(count_q);
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;

	// decode: all checks are made against the count at accept
	always_comb begin
		cmd_d    = '0;
		pos_d    = in_pos;
		status_d = ST_OK;
		count_d  = count_q;
		unique case (in_mode)
			MODE_APPEND: begin
				pos_d = count_ext;
				if (count_q >= CAP_CW) begin
					status_d = ST_FULL;
				end else begin
					cmd_d.up = 1'b1;
					count_d  = count_q + CW'(1);
				end
			end
			MODE_INSERT: begin
				if (in_pos > count_ext) begin
					status_d = ST_BOUNDS;
				end else if (count_q >= CAP_CW) begin
					status_d = ST_FULL;
				end else begin
					cmd_d.up = 1'b1;
					count_d  = count_q + CW'(1);
				end
			end
			MODE_REMOVE: begin
				if (in_pos >= count_ext) begin
					status_d = ST_BOUNDS;
				end else begin
					cmd_d.down = 1'b1;
					count_d    = count_q - CW'(1);
				end
			end
			MODE_READ: begin
				if (in_pos >= count_ext)
					status_d = ST_BOUNDS;
				else
					cmd_d.read = 1'b1;
			end
			MODE_FIND:  cmd_d.find = 1'b1;
			MODE_CLEAR: count_d = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cmd_s1  <= '0;
		end else if (accept) begin
			count_q <= count_d;
			cmd_s1  <= cmd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1    <= pos_d;
			value_s1  <= in_value;
			status_s1 <= status_d;
		end
	end

	// cell row
	cell_cmd_t         cell_cmd;
	logic [DATA_W-1:0] cell_val [CAPACITY];
	logic [DATA_W-1:0] cell_rd  [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;

	assign cell_cmd = (state_q == S_EXEC) ? cmd_s1 : '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_val;
		logic [DATA_W-1:0] right_val;
		if (i == 0) begin : g_first
			assign left_val = value_s1;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_val = cell_val[i];
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end
		ilist_cell #(
			.IDX  (i),
			.CMPW (CMPW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cell_cmd),
			.pos       (pos_s1),
			.count     (count_ext),
			.value     (value_s1),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i]),
			.hit       (cell_hit[i]),
			.rd        (cell_rd[i])
		);
	end

	// collect: first hit wins, read lines are zero except the addressed cell
	logic [CMPW-1:0]   hit_idx;
	logic              any_hit;
	logic [DATA_W-1:0] rd_all;

	always_comb begin
		hit_idx = '0;
		any_hit = 1'b0;
		rd_all  = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_hit[i]) begin
				hit_idx = CMPW'(i);
				any_hit = 1'b1;
			end
			rd_all = rd_all | cell_rd[i];
		end
	end

	assign load_out = (state_q == S_COLLECT) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (accept) state_d = S_EXEC;
			S_EXEC:    state_d = S_COLLECT;
			S_COLLECT: if (load_out) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	// cell hit and read lines only move on find and read, so mask them
	// with the command of the operation being collected
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q    <= status_s1;
			read_q      <= cmd_s1.read ? rd_all : '0;
			found_q     <= (cmd_s1.find && any_hit) ? hit_idx[POS_W-1:0] : '1;
			count_out_q <= count_ext[POS_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {count_out_q, found_q, read_q, status_q};

	`ILIST_ASSERT(a_count_bound, count_q <= CAP_CW, "list count above capacity")
	`ILIST_ASSERT_IMP(a_full_at_cap, (state_q == S_EXEC) && (status_s1 == ST_FULL),
		count_ext == CAP_CMPW, "full status while list not at capacity")
	`ILIST_ASSERT_IMP(a_accept_exec, accept, ##1 (state_q == S_EXEC),
		"accepted operation did not reach execute")
	`ILIST_ASSERT_IMP(a_load_from_collect, $rose(out_valid_q),
		$past(state_q == S_COLLECT), "result loaded outside collect step")

endmodule

[hw/rtl/ilist_cell.sv]
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one entry; shifts to or from its neighbours and flags search hits.
// ----------------------------------------------------------------------------
module ilist_cell
	import ilist_pkg::*;
#(
	parameter int IDX  = 0,
	parameter int CMPW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_cmd_t         cmd,
	input  logic [CMPW-1:0]   pos,
	input  logic [CMPW-1:0]   count,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] left_val,
	input  logic [DATA_W-1:0] right_val,
	output logic [DATA_W-1:0] val,
	output logic              hit,
	output logic [DATA_W-1:0] rd
);

	localparam logic [CMPW-1:0] IDX_C = CMPW'(IDX);

	logic [DATA_W-1:0] val_q;
	logic              hit_q;
	logic [DATA_W-1:0] rd_q;

	// entry payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.up) begin
			if (IDX_C > pos)
				val_q <= left_val;
			else if (IDX_C == pos)
				val_q <= value;
		end else if (cmd.down) begin
			if (IDX_C >= pos)
				val_q <= right_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.find || cmd.read) begin
			hit_q <= cmd.find && (IDX_C < count) && (val_q == value);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.find || cmd.read)
			rd_q <= (cmd.read && IDX_C == pos) ? val_q : '0;
	end

	assign val = val_q;
	assign hit = hit_q;
	assign rd  = rd_q;

endmodule

[tb/indexed_list_insert_remove_search_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list core - regression bench
// Drives list operations as stream transfers and predicts each result with
// a shadow copy of the list held in a small scoreboard class. A short
// directed run covers the edge cases, then random phases with differing
// source gaps and sink back-pressure fill the list, drain it and mix both.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_search_core_tb;
	import ilist_pkg::*;

	// mode 7 is outside the defined set: the core reports ok with the count
	localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
	// found_position when nothing matches, and for every non-find operation
	localparam logic [POS_W-1:0]  NOT_FOUND  = 7'h7F;
	localparam logic [DATA_W-1:0] VAL_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DATA_W-1:0] VAL_MIN    = 64'h8000_0000_0000_0000;
	localparam logic [DATA_W-1:0] VAL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [DATA_W-1:0] VAL_ALT_A  = 64'h5555_5555_5555_5555;
	localparam logic [DATA_W-1:0] VAL_ALT_B  = 64'hAAAA_AAAA_AAAA_AAAA;
	// watchdog limit, well above the length of the slowest correct run
	localparam int RUN_LIMIT = 200000;
	localparam int TAIL_CYCLES = 12;

	// one operation as carried on s_tdata
	typedef struct packed {
		logic [DATA_W-1:0] item_value;
		logic [POS_W-1:0]  position;
		logic [MODE_W-1:0] mode;
	} list_op_t;

	// one result as carried on m_tdata
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   read_value;
		logic [POS_W-1:0]    found_position;
		logic [POS_W-1:0]    entry_count;
	} list_result_t;

	typedef struct {
		int           seq;
		list_result_t res;
	} list_expect_t;

	// ------------------------------------------------------------------------
	// Scoreboard: shadow list plus the queue of results still owed
	// ------------------------------------------------------------------------
	class list_ledger;
		logic [DATA_W-1:0] cells [CAPACITY_DEF];
		int                fill;
		list_expect_t      owed[$];
		int                op_seq;
		int                mismatches;

		function new();
			fill       = 0;
			op_seq     = 0;
			mismatches = 0;
			foreach (cells[k]) cells[k] = '0;
		endfunction

		function int size();
			return fill;
		endfunction

		function logic [DATA_W-1:0] value_at(int idx);
			return cells[idx];
		endfunction

		function int outstanding();
			return owed.size();
		endfunction

		// make room at slot at, later entries move up one
		function void open_slot(int at, logic [DATA_W-1:0] v);
			int k;
			for (k = fill; k > at; k--) cells[k] = cells[k-1];
			cells[at] = v;
			fill++;
		endfunction

		// called on every accepted input transfer
		function void note_operation(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
				logic [DATA_W-1:0] value);
			list_result_t r;
			list_expect_t e;
			int at;
			int k;
			bit hit;
			r.status         = ST_OK;
			r.read_value     = '0;
			r.found_position = NOT_FOUND;
			at               = int'(pos);
			hit              = 1'b0;
			case (mode)
				MODE_APPEND: begin
					if (fill >= CAPACITY_DEF) r.status = ST_FULL;
					else open_slot(fill, value);
				end
				MODE_INSERT: begin
					// index check wins over the full check
					if (at > fill) r.status = ST_BOUNDS;
					else if (fill >= CAPACITY_DEF) r.status = ST_FULL;
					else open_slot(at, value);
				end
				MODE_REMOVE: begin
					if (at >= fill) begin
						r.status = ST_BOUNDS;
					end else begin
						for (k = at; k + 1 < fill; k++) cells[k] = cells[k+1];
						fill--;
					end
				end
				MODE_READ: begin
					if (at >= fill) r.status = ST_BOUNDS;
					else r.read_value = cells[at];
				end
				MODE_FIND: begin
					for (k = 0; k < fill && !hit; k++) begin
						if (cells[k] == value) begin
							r.found_position = 7'(k);
							hit = 1'b1;
						end
					end
				end
				MODE_CLEAR: fill = 0;
				default: ;
			endcase
			r.entry_count = 7'(fill);
			e.seq = op_seq;
			e.res = r;
			owed.push_back(e);
			op_seq++;
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		// called on every accepted output transfer
		task check_result(logic [OUT_TDATA_W-1:0] word);
			list_expect_t e;
			if (owed.size() == 0) begin
				report($sformatf("result %h with nothing expected", word));
				return;
			end
			e = owed.pop_front();
			if (word[1:0] !== e.res.status)
				report($sformatf("op %0d status %0d, expected %0d",
					e.seq, word[1:0], e.res.status));
			if (word[65:2] !== e.res.read_value)
				report($sformatf("op %0d read_value %h, expected %h",
					e.seq, word[65:2], e.res.read_value));
			if (word[72:66] !== e.res.found_position)
				report($sformatf("op %0d found_position %h, expected %h",
					e.seq, word[72:66], e.res.found_position));
			if (word[79:73] !== e.res.entry_count)
				report($sformatf("op %0d entry_count %0d, expected %0d",
					e.seq, word[79:73], e.res.entry_count));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block
	// ------------------------------------------------------------------------
	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// [2:0] mode, [9:3] position, [73:10] item_value, [79:74] zero
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// [1:0] status, [65:2] read_value, [72:66] found_position, [79:73] entry_count
	logic [OUT_TDATA_W-1:0] m_tdata;

	int src_idle_pct   = 0;  // chance in 100 of a source gap per cycle
	int sink_stall_pct = 0;  // chance in 100 of m_tready low per cycle
	int cycle_count    = 0;

	list_ledger ledger = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	indexed_list_insert_remove_search_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// sink side: random back-pressure, check every result transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) ledger.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("indexed_list_insert_remove_search_core regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Source side
	// ------------------------------------------------------------------------
	// hold the operation until the transfer, then maybe leave a gap
	task automatic send_operation(input logic [MODE_W-1:0] mode,
			input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] value);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, value, pos, mode};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ledger.note_operation(mode, pos, value);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// source goes quiet until every owed result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (ledger.outstanding() != 0) @(posedge clk);
	endtask

	// random operation shaped by the shadow list: positions mostly in range,
	// find keys often taken from the list so hits are common
	function automatic list_op_t random_list_op(int grow_pct, int clear_pct);
		list_op_t op;
		int n;
		int roll;
		n = ledger.size();
		roll = $urandom_range(99);
		if (roll < grow_pct) begin
			op.mode = ($urandom_range(1) == 0) ? MODE_APPEND : MODE_INSERT;
		end else if (roll < grow_pct + clear_pct) begin
			op.mode = MODE_CLEAR;
		end else begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5: op.mode = MODE_REMOVE;
				6, 7, 8, 9:       op.mode = MODE_READ;
				10, 11, 12, 13,
				14, 15:           op.mode = MODE_FIND;
				16, 17:           op.mode = MODE_SIZE;
				18:               op.mode = MODE_SPARE;
				default:          op.mode = MODE_READ;
			endcase
		end
		if (n > 0 && $urandom_range(9) < 8)
			op.position = (op.mode == MODE_INSERT) ? 7'($urandom_range(n))
				: 7'($urandom_range(n - 1));
		else
			op.position = 7'($urandom_range(CAPACITY_DEF));
		case ($urandom_range(9))
			0:       op.item_value = VAL_MIN;
			1:       op.item_value = VAL_MAX;
			2:       op.item_value = ($urandom_range(1) == 0) ? '0 : VAL_ONES;
			3, 4, 5: op.item_value = (n > 0) ? ledger.value_at($urandom_range(n - 1))
				: {$urandom, $urandom};
			default: op.item_value = {$urandom, $urandom};
		endcase
		return op;
	endfunction

	task automatic random_phase(int items, int src_pct, int sink_pct, int grow_pct,
			int clear_pct);
		list_op_t op;
		int i;
		drain_results();
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		for (i = 0; i < items; i++) begin
			op = random_list_op(grow_pct, clear_pct);
			send_operation(op.mode, op.position, op.item_value);
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, shifting inserts, duplicates, removals at
		// both ends, out-of-range positions and the unused mode
		send_operation(MODE_SIZE,   7'd0,  '0);
		send_operation(MODE_READ,   7'd0,  '0);        // read on empty list
		send_operation(MODE_REMOVE, 7'd0,  '0);        // remove on empty list
		send_operation(MODE_INSERT, 7'd1,  VAL_ALT_A); // insert past end
		send_operation(MODE_FIND,   7'd0,  '0);        // find on empty list
		send_operation(MODE_APPEND, 7'd0,  VAL_MAX);
		send_operation(MODE_APPEND, 7'd0,  VAL_MIN);
		send_operation(MODE_INSERT, 7'd0,  VAL_ONES);  // insert at head
		send_operation(MODE_INSERT, 7'd3,  '0);        // insert at count appends
		send_operation(MODE_INSERT, 7'd1,  VAL_ALT_A);
		send_operation(MODE_APPEND, 7'd0,  VAL_MIN);   // duplicate value
		send_operation(MODE_READ,   7'd0,  '0);
		send_operation(MODE_READ,   7'd5,  '0);        // last entry
		send_operation(MODE_READ,   7'd6,  '0);        // one past the end
		send_operation(MODE_READ,   7'd64, '0);
		send_operation(MODE_FIND,   7'd0,  VAL_MIN);   // first of two matches
		send_operation(MODE_FIND,   7'd0,  VAL_ALT_B); // no match
		send_operation(MODE_REMOVE, 7'd0,  '0);        // remove head
		send_operation(MODE_REMOVE, 7'd4,  '0);        // remove tail
		send_operation(MODE_REMOVE, 7'd4,  '0);        // now out of range
		send_operation(MODE_INSERT, 7'd64, VAL_ALT_B); // far past end
		send_operation(MODE_SPARE,  7'd0,  VAL_ALT_B);
		send_operation(MODE_CLEAR,  7'd0,  '0);
		send_operation(MODE_SIZE,   7'd0,  '0);

		// fill to capacity and keep hitting the full case, back to back
		random_phase(120, 0, 0, 85, 0);
		// mostly draining, sparse source
		random_phase(90, 87, 0, 30, 2);
		// balanced mix under heavy back-pressure
		random_phase(90, 0, 87, 55, 2);
		// light gaps on both sides
		random_phase(100, 21, 21, 50, 3);

		drain_results();
		sink_stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);

		if (ledger.mismatches == 0 && ledger.outstanding() == 0)
			$display("indexed_list_insert_remove_search_core regression: pass");
		else
			$display("indexed_list_insert_remove_search_core regression: fail");
		$finish;
	end

endmodule
